// ===== rtl/duc_pkg.sv =====
// shared constants, command codes and helper functions for the duration unit converter
`timescale 1ns / 1ps

package duc_pkg;

    // command codes carried on the input tuser
    typedef enum logic [3:0] {
        CMD_TRUNC_S  = 4'd0,
        CMD_AWAY_S   = 4'd1,
        CMD_TRUNC_MS = 4'd2,
        CMD_AWAY_MS  = 4'd3,
        CMD_TRUNC_US = 4'd4,
        CMD_AWAY_US  = 4'd5,
        CMD_NS       = 4'd6,
        CMD_NORM_NS  = 4'd7,
        CMD_NORM_US  = 4'd8
    } t_cmd;

    // target unit of a conversion
    typedef enum logic [1:0] {
        DIV_S  = 2'd0,
        DIV_MS = 2'd1,
        DIV_US = 2'd2,
        DIV_NS = 2'd3
    } t_div;

    localparam logic [63:0] S64_MAX  = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] S64_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [29:0] NS_PER_S = 30'd1000000000;
    localparam logic [29:0] NS_MAX   = 30'd999999999;
    localparam logic [29:0] NS_PER_MS = 30'd1000000;
    localparam logic [29:0] NS_PER_US = 30'd1000;
    localparam logic [32:0] US_PER_S  = 33'd1000000;

    // floor(x / 1e6) for x below 2^33: (x * RECIP_NORM_US) >> 53
    localparam logic [33:0] RECIP_NORM_US = 34'd9007199255;
    // bias that makes a signed 32-bit microsecond count non-negative
    localparam logic [32:0] US_NORM_BIAS   = 33'd2148000000;
    localparam logic [12:0] US_NORM_BIAS_Q = 13'd2148;

    // floor(ns / 1e6) = (ns * RECIP_MS) >> 50, floor(ns / 1e3) = (ns * RECIP_US) >> 40
    localparam logic [30:0] RECIP_MS = 31'd1125899907;
    localparam logic [30:0] RECIP_US = 31'd1099511628;

    // unit selected by a conversion command
    function automatic t_div cmd_div(input logic [3:0] cmd);
        t_div d;
        case (cmd)
            CMD_TRUNC_S, CMD_AWAY_S:   d = DIV_S;
            CMD_TRUNC_MS, CMD_AWAY_MS: d = DIV_MS;
            CMD_TRUNC_US, CMD_AWAY_US: d = DIV_US;
            CMD_NS:                    d = DIV_NS;
            default:                   d = DIV_S;
        endcase
        return d;
    endfunction

    // rounding away from zero
    function automatic logic cmd_away(input logic [3:0] cmd);
        logic a;
        case (cmd)
            CMD_AWAY_S, CMD_AWAY_MS, CMD_AWAY_US: a = 1'b1;
            default:                              a = 1'b0;
        endcase
        return a;
    endfunction

    // units per second
    function automatic logic [29:0] div_scale(input t_div d);
        logic [29:0] p;
        case (d)
            DIV_S:   p = 30'd1;
            DIV_MS:  p = 30'd1000;
            DIV_US:  p = 30'd1000000;
            DIV_NS:  p = NS_PER_S;
            default: p = 30'd1;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/duration_unit_converter.sv =====
// duration unit converter: eight-stage pipeline from seconds plus nanoseconds to a unit count
`timescale 1ns / 1ps
// an accepted input transaction moves through every stage register to the master side
// one transaction per cycle when not stalled; each stage holds one item with its own valid bit
// the depth comes from the chain of constant multipliers (reciprocal divide, remainder
// check, scale to the target unit) and the final wide add and clamp
// reset (synchronous, active low) clears the stage valid bits only

module duration_unit_converter
    import duc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // whole_seconds[63:0], sub_second[95:64]
    input  logic [3:0]  s_axis_tuser,  // command[3:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,  // result_value[63:0], result_nanoseconds[93:64], zero
    output logic [0:0]  m_axis_tuser   // saturated[0]
);

    // stage handshake
    logic [8:1] r_vld;
    logic [8:1] n_vld;
    logic [8:1] rdy;

    // stage 1: nanosecond normalization quotient and remainder
    logic [3:0]         r_s1_cmd, n_s1_cmd;
    logic [63:0]        r_s1_sec, n_s1_sec;
    logic signed [2:0]  r_s1_qn, n_s1_qn;
    logic [29:0]        r_s1_rn, n_s1_rn;
    logic [32:0]        r_s1_uo, n_s1_uo;
    logic signed [31:0] in_sub;
    logic signed [33:0] s1_off;
    logic signed [33:0] s1_rem;

    // stage 2: seconds adjust, microsecond quotient multiply
    logic [3:0]  r_s2_cmd, n_s2_cmd;
    logic [63:0] r_s2_sec, n_s2_sec;
    logic [29:0] r_s2_ns, n_s2_ns;
    logic        r_s2_sat, n_s2_sat;
    logic [32:0] r_s2_uo;
    logic [12:0] r_s2_qq, n_s2_qq;
    logic [66:0] s2_prod;
    logic [64:0] s2_sum;

    // stage 3: divide multiply, microsecond remainder multiply
    logic [3:0]         r_s3_cmd;
    logic [63:0]        r_s3_sec;
    logic [29:0]        r_s3_ns;
    logic               r_s3_sat;
    logic [32:0]        r_s3_uo;
    logic [32:0]        r_s3_qm, n_s3_qm;
    logic signed [12:0] r_s3_q8, n_s3_q8;
    logic [60:0]        r_s3_pd, n_s3_pd;
    logic [30:0]        s3_recip;

    // stage 4: quotient select, microsecond normalization seconds adjust
    logic [3:0]  r_s4_cmd, n_s4_cmd;
    logic [63:0] r_s4_sec, n_s4_sec;
    logic [29:0] r_s4_ns;
    logic        r_s4_sat, n_s4_sat;
    logic        r_s4_pos, n_s4_pos;
    logic [19:0] r_s4_r8, n_s4_r8;
    logic [29:0] r_s4_dq, n_s4_dq;
    logic [64:0] s4_sum;
    logic [32:0] s4_rem;

    // stage 5: remainder check and rounding, microsecond remainder to ns
    logic [3:0]  r_s5_cmd;
    logic [63:0] r_s5_sec;
    logic [29:0] r_s5_ns, n_s5_ns;
    logic        r_s5_sat;
    logic [29:0] r_s5_a, n_s5_a;
    logic [29:0] s5_chk;
    logic        s5_rnz;
    logic        s5_inc;

    // stage 6: scale seconds by units per second, split in two halves
    logic [3:0]         r_s6_cmd;
    logic [63:0]        r_s6_sec;
    logic [29:0]        r_s6_ns;
    logic               r_s6_sat;
    logic [29:0]        r_s6_a;
    logic [61:0]        r_s6_lo, n_s6_lo;
    logic signed [61:0] r_s6_hi, n_s6_hi;
    logic [29:0]        s6_scale;

    // stage 7: add rounded sub-unit count to low half
    logic [3:0]         r_s7_cmd;
    logic [63:0]        r_s7_sec;
    logic [29:0]        r_s7_ns;
    logic               r_s7_sat;
    logic signed [61:0] r_s7_hi;
    logic [62:0]        r_s7_lo, n_s7_lo;

    // stage 8: combine halves, clamp, output register
    logic [63:0]        r_s8_val, n_s8_val;
    logic [29:0]        r_s8_ns, n_s8_ns;
    logic               r_s8_sat, n_s8_sat;
    logic signed [63:0] s8_vh;
    logic               s8_in_rng;

    // ready chain, a stage loads when empty or when its successor moves
    always_comb begin
        rdy[8] = !r_vld[8] || m_axis_tready;
        for (int k = 7; k >= 1; k--) begin
            rdy[k] = !r_vld[k] || rdy[k + 1];
        end
        n_vld[1] = rdy[1] ? s_axis_tvalid : r_vld[1];
        for (int k = 2; k <= 8; k++) begin
            n_vld[k] = rdy[k] ? r_vld[k - 1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign s_axis_tready = rdy[1];

    // stage 1: floor division of the raw sub-second by 1e9 through compares
    always_comb begin
        in_sub   = $signed(s_axis_tdata[95:64]);
        n_s1_cmd = s_axis_tuser;
        n_s1_sec = s_axis_tdata[63:0];
        if (in_sub >= 32'sd2000000000) begin
            n_s1_qn = 3'sd2;
            s1_off  = 34'sd2000000000;
        end else if (in_sub >= 32'sd1000000000) begin
            n_s1_qn = 3'sd1;
            s1_off  = 34'sd1000000000;
        end else if (in_sub >= 32'sd0) begin
            n_s1_qn = 3'sd0;
            s1_off  = 34'sd0;
        end else if (in_sub >= -32'sd1000000000) begin
            n_s1_qn = -3'sd1;
            s1_off  = -34'sd1000000000;
        end else if (in_sub >= -32'sd2000000000) begin
            n_s1_qn = -3'sd2;
            s1_off  = -34'sd2000000000;
        end else begin
            n_s1_qn = -3'sd3;
            s1_off  = -34'sd3000000000;
        end
        s1_rem  = $signed({{2{in_sub[31]}}, in_sub}) - s1_off;
        n_s1_rn = s1_rem[29:0];
        n_s1_uo = {in_sub[31], in_sub} + US_NORM_BIAS;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_s1_cmd <= n_s1_cmd;
            r_s1_sec <= n_s1_sec;
            r_s1_qn  <= n_s1_qn;
            r_s1_rn  <= n_s1_rn;
            r_s1_uo  <= n_s1_uo;
        end
    end

    // stage 2: saturating seconds adjust for ns normalization, us quotient by reciprocal
    always_comb begin
        s2_prod  = 67'(r_s1_uo) * 67'(RECIP_NORM_US);
        n_s2_qq  = s2_prod[65:53];
        n_s2_cmd = r_s1_cmd;
        s2_sum   = {r_s1_sec[63], r_s1_sec} + {{62{r_s1_qn[2]}}, r_s1_qn};
        if (r_s1_cmd == CMD_NORM_US) begin
            n_s2_sec = r_s1_sec;
            n_s2_ns  = '0;
            n_s2_sat = 1'b0;
        end else if (s2_sum[64] != s2_sum[63]) begin
            n_s2_sec = r_s1_qn[2] ? S64_MIN : S64_MAX;
            n_s2_ns  = r_s1_qn[2] ? 30'd0 : NS_MAX;
            n_s2_sat = 1'b1;
        end else begin
            n_s2_sec = s2_sum[63:0];
            n_s2_ns  = r_s1_rn;
            n_s2_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_s2_cmd <= n_s2_cmd;
            r_s2_sec <= n_s2_sec;
            r_s2_ns  <= n_s2_ns;
            r_s2_sat <= n_s2_sat;
            r_s2_uo  <= r_s1_uo;
            r_s2_qq  <= n_s2_qq;
        end
    end

    // stage 3: reciprocal multiply for the conversion divide, us remainder product
    always_comb begin
        n_s3_qm = 33'(r_s2_qq) * US_PER_S;
        n_s3_q8 = $signed(r_s2_qq - US_NORM_BIAS_Q);
        case (cmd_div(r_s2_cmd))
            DIV_MS:  s3_recip = RECIP_MS;
            DIV_US:  s3_recip = RECIP_US;
            default: s3_recip = '0;
        endcase
        n_s3_pd = 61'(r_s2_ns) * 61'(s3_recip);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_s3_cmd <= r_s2_cmd;
            r_s3_sec <= r_s2_sec;
            r_s3_ns  <= r_s2_ns;
            r_s3_sat <= r_s2_sat;
            r_s3_uo  <= r_s2_uo;
            r_s3_qm  <= n_s3_qm;
            r_s3_q8  <= n_s3_q8;
            r_s3_pd  <= n_s3_pd;
        end
    end

    // stage 4: quotient pick, saturating seconds adjust for us normalization
    always_comb begin
        n_s4_cmd = r_s3_cmd;
        s4_rem   = r_s3_uo - r_s3_qm;
        n_s4_r8  = s4_rem[19:0];
        s4_sum   = {r_s3_sec[63], r_s3_sec} + {{52{r_s3_q8[12]}}, r_s3_q8};
        n_s4_pos = !r_s3_q8[12];
        if (r_s3_cmd == CMD_NORM_US) begin
            if (s4_sum[64] != s4_sum[63]) begin
                n_s4_sec = r_s3_q8[12] ? S64_MIN : S64_MAX;
                n_s4_sat = 1'b1;
            end else begin
                n_s4_sec = s4_sum[63:0];
                n_s4_sat = 1'b0;
            end
        end else begin
            n_s4_sec = r_s3_sec;
            n_s4_sat = r_s3_sat;
        end
        case (cmd_div(r_s3_cmd))
            DIV_MS:  n_s4_dq = 30'(r_s3_pd[60:50]);
            DIV_US:  n_s4_dq = 30'(r_s3_pd[60:40]);
            DIV_NS:  n_s4_dq = r_s3_ns;
            default: n_s4_dq = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_s4_cmd <= n_s4_cmd;
            r_s4_sec <= n_s4_sec;
            r_s4_ns  <= r_s3_ns;
            r_s4_sat <= n_s4_sat;
            r_s4_pos <= n_s4_pos;
            r_s4_r8  <= n_s4_r8;
            r_s4_dq  <= n_s4_dq;
        end
    end

    // stage 5: nonzero remainder check and rounding increment, us remainder to ns
    always_comb begin
        case (cmd_div(r_s4_cmd))
            DIV_MS:  s5_chk = r_s4_dq * NS_PER_MS;
            DIV_US:  s5_chk = r_s4_dq * NS_PER_US;
            default: s5_chk = '0;
        endcase
        case (cmd_div(r_s4_cmd))
            DIV_S:   s5_rnz = (r_s4_ns != '0);
            DIV_MS:  s5_rnz = (s5_chk != r_s4_ns);
            DIV_US:  s5_rnz = (s5_chk != r_s4_ns);
            default: s5_rnz = 1'b0;
        endcase
        s5_inc = s5_rnz && (cmd_away(r_s4_cmd) ? !r_s4_sec[63] : r_s4_sec[63]);
        n_s5_a = r_s4_dq + 30'(s5_inc);
        if (r_s4_cmd == CMD_NORM_US) begin
            if (r_s4_sat) begin
                n_s5_ns = r_s4_pos ? NS_MAX : 30'd0;
            end else begin
                n_s5_ns = 30'(r_s4_r8) * NS_PER_US;
            end
        end else begin
            n_s5_ns = r_s4_ns;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r_s5_cmd <= r_s4_cmd;
            r_s5_sec <= r_s4_sec;
            r_s5_ns  <= n_s5_ns;
            r_s5_sat <= r_s4_sat;
            r_s5_a   <= n_s5_a;
        end
    end

    // stage 6: seconds times units per second, low half unsigned, high half signed
    always_comb begin
        s6_scale = div_scale(cmd_div(r_s5_cmd));
        n_s6_lo  = 62'(r_s5_sec[31:0]) * 62'(s6_scale);
        n_s6_hi  = $signed(r_s5_sec[63:32]) * $signed({1'b0, s6_scale});
    end

    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            r_s6_cmd <= r_s5_cmd;
            r_s6_sec <= r_s5_sec;
            r_s6_ns  <= r_s5_ns;
            r_s6_sat <= r_s5_sat;
            r_s6_a   <= r_s5_a;
            r_s6_lo  <= n_s6_lo;
            r_s6_hi  <= n_s6_hi;
        end
    end

    // stage 7: fold in the sub-unit count
    assign n_s7_lo = {1'b0, r_s6_lo} + {33'b0, r_s6_a};

    always_ff @(posedge i_clk) begin
        if (rdy[7]) begin
            r_s7_cmd <= r_s6_cmd;
            r_s7_sec <= r_s6_sec;
            r_s7_ns  <= r_s6_ns;
            r_s7_sat <= r_s6_sat;
            r_s7_hi  <= r_s6_hi;
            r_s7_lo  <= n_s7_lo;
        end
    end

    // stage 8: upper word of the exact result, range check and clamp, or normalized pass-through
    always_comb begin
        s8_vh     = $signed({{2{r_s7_hi[61]}}, r_s7_hi}) + $signed({33'b0, r_s7_lo[62:32]});
        s8_in_rng = (&s8_vh[63:31]) || !(|s8_vh[63:31]);
        case (r_s7_cmd)
            CMD_TRUNC_S, CMD_AWAY_S, CMD_TRUNC_MS, CMD_AWAY_MS,
            CMD_TRUNC_US, CMD_AWAY_US, CMD_NS: begin
                if (s8_in_rng) begin
                    n_s8_val = {s8_vh[31:0], r_s7_lo[31:0]};
                end else begin
                    n_s8_val = s8_vh[63] ? S64_MIN : S64_MAX;
                end
                n_s8_ns  = '0;
                n_s8_sat = r_s7_sat || !s8_in_rng;
            end
            CMD_NORM_NS, CMD_NORM_US: begin
                n_s8_val = r_s7_sec;
                n_s8_ns  = r_s7_ns;
                n_s8_sat = r_s7_sat;
            end
            default: begin
                n_s8_val = '0;
                n_s8_ns  = '0;
                n_s8_sat = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy[8]) begin
            r_s8_val <= n_s8_val;
            r_s8_ns  <= n_s8_ns;
            r_s8_sat <= n_s8_sat;
        end
    end

    // master side
    assign m_axis_tvalid   = r_vld[8];
    assign m_axis_tdata    = {2'b00, r_s8_ns, r_s8_val};
    assign m_axis_tuser[0] = r_s8_sat;

    // an accepted transaction always lands in the first stage
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[1])
        else $error("accepted transaction not captured in stage 1");

    // a full pipeline with a stalled output takes nothing in
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while pipeline full and stalled");

    // normalized nanoseconds stay below one second
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_s8_ns < NS_PER_S)
        else $error("result nanoseconds out of range");

    // only a positive clamp leaves nonzero nanoseconds behind
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_s8_sat && (r_s8_ns != '0) |-> r_s8_val == S64_MAX)
        else $error("saturated result with nanoseconds is not the maximum");

endmodule
